FILE: rtl/c2i_pkg.sv
// ----------------------------------------------------------------------------
// c2i_pkg: shared types and constants for the col2im accumulator
// Beat payloads, configuration record, register indexes and fixed limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package c2i_pkg;

   // Default geometry of the image store
   localparam int CHANNELS_DEF    = 16;
   localparam int MAX_IMAGE_H_DEF = 32;
   localparam int MAX_IMAGE_W_DEF = 32;

   // Limits on kernel taps and output positions of accumulate beats
   localparam int MAX_KERNEL = 16;
   localparam int MAX_OUT    = 64;

   // Width used for position arithmetic (holds 63*15 + 15*15 and all limits)
   localparam int POS_W = 12;

   localparam int VALUE_W = 32;
   localparam int ACC_W   = 40;

   localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   localparam logic FUNC_ACCUM = 1'b0;
   localparam logic FUNC_READ  = 1'b1;

   typedef enum logic [3:0] {
      CSR_STRIDE_H = 4'd0,
      CSR_STRIDE_W = 4'd1,
      CSR_PAD_H    = 4'd2,
      CSR_PAD_W    = 4'd3,
      CSR_DIL_H    = 4'd4,
      CSR_DIL_W    = 4'd5,
      CSR_IMAGE_H  = 4'd6,
      CSR_IMAGE_W  = 4'd7
   } c2i_csr_type;

   typedef struct packed {
      logic              func;
      logic [3:0]        channel;
      logic [3:0]        kernel_row;
      logic [3:0]        kernel_col;
      logic [5:0]        row_index;
      logic [5:0]        col_index;
      logic signed [31:0] value;
   } c2i_req_type;

   typedef struct packed {
      logic signed [39:0] pixel_value;
      logic               in_range;
   } c2i_rsp_type;

   typedef struct packed {
      logic [3:0] stride_h;
      logic [3:0] stride_w;
      logic [3:0] pad_h;
      logic [3:0] pad_w;
      logic [3:0] dil_h;
      logic [3:0] dil_w;
      logic [5:0] image_h;
      logic [5:0] image_w;
   } c2i_cfg_type;

   // Classification of a queued command
   typedef struct packed {
      logic is_read;
      logic hit;      // position lies inside the image and all indexes are in range
   } c2i_op_type;

endpackage

`default_nettype wire

FILE: rtl/c2i_front.sv
// ----------------------------------------------------------------------------
// c2i_front: command decode and address generation
// Maps an accepted beat to an image position, checks it and forms the address.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module c2i_front #(
   parameter int CHANNELS    = 16,
   parameter int MAX_IMAGE_H = 32,
   parameter int MAX_IMAGE_W = 32,
   parameter int ADDR_W      = 14
) (
   input  wire                 accept,
   input  c2i_pkg::c2i_req_type req_data,
   input  c2i_pkg::c2i_cfg_type cfg,
   output logic                push,
   output c2i_pkg::c2i_op_type  push_op,
   output logic [ADDR_W-1:0]   push_addr,
   output logic [31:0]         push_value
);
   import c2i_pkg::*;

   logic              is_read;
   logic [POS_W-1:0]  row_pos, col_pos, row_pad, col_pad;
   logic [POS_W-1:0]  row_rel, col_rel, h_eff, w_eff;
   logic              ch_ok, row_ok, col_ok, tap_ok, out_ok, hit;

   always_comb begin
      is_read = (req_data.func == FUNC_READ);

      // Smaller of configured size and store size
      h_eff = (POS_W'(cfg.image_h) < POS_W'(MAX_IMAGE_H)) ?
              POS_W'(cfg.image_h) : POS_W'(MAX_IMAGE_H);
      w_eff = (POS_W'(cfg.image_w) < POS_W'(MAX_IMAGE_W)) ?
              POS_W'(cfg.image_w) : POS_W'(MAX_IMAGE_W);

      if (is_read) begin
         row_pos = POS_W'(req_data.row_index);
         col_pos = POS_W'(req_data.col_index);
         row_pad = '0;
         col_pad = '0;
      end else begin
         row_pos = POS_W'(req_data.row_index) * POS_W'(cfg.stride_h)
                 + POS_W'(req_data.kernel_row) * POS_W'(cfg.dil_h);
         col_pos = POS_W'(req_data.col_index) * POS_W'(cfg.stride_w)
                 + POS_W'(req_data.kernel_col) * POS_W'(cfg.dil_w);
         row_pad = POS_W'(cfg.pad_h);
         col_pad = POS_W'(cfg.pad_w);
      end

      row_rel = row_pos - row_pad;
      col_rel = col_pos - col_pad;

      // Negative positions show up as pos < pad
      row_ok = (row_pos >= row_pad) && (row_rel < h_eff);
      col_ok = (col_pos >= col_pad) && (col_rel < w_eff);
      ch_ok  = POS_W'(req_data.channel) < POS_W'(CHANNELS);
      tap_ok = (POS_W'(req_data.kernel_row) < POS_W'(MAX_KERNEL)) &&
               (POS_W'(req_data.kernel_col) < POS_W'(MAX_KERNEL));
      out_ok = (POS_W'(req_data.row_index) < POS_W'(MAX_OUT)) &&
               (POS_W'(req_data.col_index) < POS_W'(MAX_OUT));
      hit    = ch_ok && row_ok && col_ok && (is_read || (tap_ok && out_ok));

      // Accumulates that miss are dropped here; reads always get a response
      push            = accept && (is_read || hit);
      push_op.is_read = is_read;
      push_op.hit     = hit;
      push_addr       = ADDR_W'(req_data.channel) * ADDR_W'(MAX_IMAGE_H * MAX_IMAGE_W)
                      + ADDR_W'(row_rel) * ADDR_W'(MAX_IMAGE_W)
                      + ADDR_W'(col_rel);
      push_value      = req_data.value;
   end

endmodule

`default_nettype wire

FILE: rtl/c2i_queue.sv
// ----------------------------------------------------------------------------
// c2i_queue: short command queue
// Two-entry FIFO between the front decode and the back store update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module c2i_queue #(
   parameter int WIDTH = 48
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              push,
   input  wire [WIDTH-1:0]  push_data,
   input  wire              pop,
   output logic             not_empty,
   output logic             full,
   output logic [WIDTH-1:0] pop_data
);
   import c2i_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   always_comb begin
      not_empty = (count_ff != '0);
      full      = (count_ff == CNT_W'(QUEUE_DEPTH));
      do_push   = push && !full;
      do_pop    = pop && not_empty;
      pop_data  = entry_ff[rd_ptr_ff];
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/c2i_back.sv
// ----------------------------------------------------------------------------
// c2i_back: image store and read-modify-write pipeline
// Holds the store, clears it after reset, accumulates, reads out and clears pixels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module c2i_back #(
   parameter int CHANNELS    = 16,
   parameter int MAX_IMAGE_H = 32,
   parameter int MAX_IMAGE_W = 32,
   parameter int ADDR_W      = 14
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  entry_valid,
   input  c2i_pkg::c2i_op_type  entry_op,
   input  wire [ADDR_W-1:0]     entry_addr,
   input  wire [31:0]           entry_value,
   output logic                 pop,
   output logic                 clearing,
   output logic                 rsp_strobe,
   output c2i_pkg::c2i_rsp_type rsp_data
);
   import c2i_pkg::*;

   localparam int DEPTH = CHANNELS * MAX_IMAGE_H * MAX_IMAGE_W;

   logic [ACC_W-1:0]   store_mem [DEPTH];

   logic               clearing_ff, clearing_in;
   logic [ADDR_W-1:0]  clear_addr_ff, clear_addr_in;

   // Execute stage
   logic               s2_valid_ff, s2_valid_in;
   c2i_op_type         s2_op_ff;
   logic [ADDR_W-1:0]  s2_addr_ff;
   logic [31:0]        s2_value_ff;
   logic [ACC_W-1:0]   rd_data_ff;
   logic               fwd_hit_ff, fwd_hit_in;
   logic [ACC_W-1:0]   fwd_data_ff;

   logic               rsp_strobe_ff, rsp_strobe_in;
   c2i_rsp_type        rsp_data_ff, rsp_data_in;

   logic [ACC_W-1:0]   old_data, sat_data, wr_data, mem_wdata;
   logic [ACC_W:0]     sum;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;

   always_comb begin
      pop         = entry_valid && !clearing_ff;
      s2_valid_in = pop;

      clearing_in   = clearing_ff;
      clear_addr_in = clear_addr_ff;
      if (clearing_ff) begin
         clear_addr_in = clear_addr_ff + 1'b1;
         if (clear_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clearing_in = 1'b0;
         end
      end

      // Back-to-back beats on one address: take the value being written
      old_data = fwd_hit_ff ? fwd_data_ff : rd_data_ff;
      sum      = {old_data[ACC_W-1], old_data}
               + {{(ACC_W + 1 - VALUE_W){s2_value_ff[VALUE_W-1]}}, s2_value_ff};
      if (sum[ACC_W] != sum[ACC_W-1]) begin
         sat_data = sum[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
         sat_data = sum[ACC_W-1:0];
      end
      wr_data = s2_op_ff.is_read ? '0 : sat_data;

      fwd_hit_in = s2_valid_ff && s2_op_ff.hit && (s2_addr_ff == entry_addr);

      mem_we    = clearing_ff || (s2_valid_ff && s2_op_ff.hit);
      mem_waddr = clearing_ff ? clear_addr_ff : s2_addr_ff;
      mem_wdata = clearing_ff ? '0 : wr_data;

      rsp_strobe_in           = s2_valid_ff && s2_op_ff.is_read;
      rsp_data_in.pixel_value = s2_op_ff.hit ? old_data : '0;
      rsp_data_in.in_range    = s2_op_ff.hit;

      clearing   = clearing_ff;
      rsp_strobe = rsp_strobe_ff;
      rsp_data   = rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff   <= 1'b1;
         clear_addr_ff <= '0;
         s2_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         clearing_ff   <= clearing_in;
         clear_addr_ff <= clear_addr_in;
         s2_valid_ff   <= s2_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      s2_op_ff    <= entry_op;
      s2_addr_ff  <= entry_addr;
      s2_value_ff <= entry_value;
      fwd_hit_ff  <= fwd_hit_in;
      fwd_data_ff <= wr_data;
      rsp_data_ff <= rsp_data_in;
   end

   // Store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      if (pop && entry_op.hit) begin
         rd_data_ff <= store_mem[entry_addr];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/col2im_accumulate.sv
// ----------------------------------------------------------------------------
// col2im_accumulate: dilated col2im fold by accumulation
// Top level: configuration registers, command front, queue and store back.
// ----------------------------------------------------------------------------
// Usage
//   Commands come in on req_data, taken at a clock edge with start high and
//   busy low. func=0 adds a Q16.16 column value into the per-channel image
//   at row_index*stride_h - pad_h + kernel_row*dil_h (columns likewise),
//   saturating to Q24.16; positions off the image are dropped silently.
//   func=1 reads and clears one pixel and always returns one result beat.
//   Results show on rsp_data for exactly one cycle with rsp_strobe high;
//   the receiver must take them, there is no back-pressure.
//   A read's result beat goes out of the result register after its command
//   has passed the queue entry and the execute stage. Throughput: one
//   command per cycle while busy is low; the back pops one queued command
//   per cycle unless clearing, using one read and one write port on the
//   store. Back-to-back hits on one pixel are forwarded in the back pipeline.
//   Reset: registers return to stride 1, pad 0, dilation 1, image 32x32,
//   then the store is swept to zero, one entry per cycle, over all
//   CHANNELS*MAX_IMAGE_H*MAX_IMAGE_W entries (16384 by default); busy is
//   high meanwhile. Register writes on the csr_ channel are taken at any
//   time but must only be issued while no command is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module col2im_accumulate #(
   parameter int CHANNELS    = c2i_pkg::CHANNELS_DEF,
   parameter int MAX_IMAGE_H = c2i_pkg::MAX_IMAGE_H_DEF,
   parameter int MAX_IMAGE_W = c2i_pkg::MAX_IMAGE_W_DEF
) (
   input  wire                  clock,
   input  wire                  reset,
   // command beats
   input  wire                  start,
   output logic                 busy,
   input  c2i_pkg::c2i_req_type req_data,
   // result beats
   output logic                 rsp_strobe,
   output c2i_pkg::c2i_rsp_type rsp_data,
   // register writes
   input  wire                  csr_valid,
   output logic                 csr_ready,
   input  wire [3:0]            csr_index,
   input  wire [5:0]            csr_data
);
   import c2i_pkg::*;

   localparam int DEPTH   = CHANNELS * MAX_IMAGE_H * MAX_IMAGE_W;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ENTRY_W = $bits(c2i_op_type) + ADDR_W + VALUE_W;

   c2i_cfg_type        cfg_ff, cfg_in;

   logic               accept;
   logic               push;
   c2i_op_type         push_op;
   logic [ADDR_W-1:0]  push_addr;
   logic [31:0]        push_value;

   logic               q_not_empty, q_full, q_pop;
   logic [ENTRY_W-1:0] q_out;

   c2i_op_type         entry_op;
   logic [ADDR_W-1:0]  entry_addr;
   logic [31:0]        entry_value;
   logic               clearing;

   // Register file: writes always accepted, unknown indexes ignored
   always_comb begin
      csr_ready = 1'b1;
      cfg_in    = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_STRIDE_H: cfg_in.stride_h = csr_data[3:0];
            CSR_STRIDE_W: cfg_in.stride_w = csr_data[3:0];
            CSR_PAD_H:    cfg_in.pad_h    = csr_data[3:0];
            CSR_PAD_W:    cfg_in.pad_w    = csr_data[3:0];
            CSR_DIL_H:    cfg_in.dil_h    = csr_data[3:0];
            CSR_DIL_W:    cfg_in.dil_w    = csr_data[3:0];
            CSR_IMAGE_H:  cfg_in.image_h  = csr_data;
            CSR_IMAGE_W:  cfg_in.image_w  = csr_data;
            default:      cfg_in          = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stride_h <= 4'd1;
         cfg_ff.stride_w <= 4'd1;
         cfg_ff.pad_h    <= 4'd0;
         cfg_ff.pad_w    <= 4'd0;
         cfg_ff.dil_h    <= 4'd1;
         cfg_ff.dil_w    <= 4'd1;
         cfg_ff.image_h  <= 6'd32;
         cfg_ff.image_w  <= 6'd32;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Hold off commands during the store sweep or when the queue is full
   assign busy   = clearing || q_full;
   assign accept = start && !busy;

   c2i_front #(
      .CHANNELS    (CHANNELS),
      .MAX_IMAGE_H (MAX_IMAGE_H),
      .MAX_IMAGE_W (MAX_IMAGE_W),
      .ADDR_W      (ADDR_W)
   ) u_front (
      .accept     (accept),
      .req_data   (req_data),
      .cfg        (cfg_ff),
      .push       (push),
      .push_op    (push_op),
      .push_addr  (push_addr),
      .push_value (push_value)
   );

   c2i_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_op, push_addr, push_value}),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .full      (q_full),
      .pop_data  (q_out)
   );

   assign {entry_op, entry_addr, entry_value} = q_out;

   c2i_back #(
      .CHANNELS    (CHANNELS),
      .MAX_IMAGE_H (MAX_IMAGE_H),
      .MAX_IMAGE_W (MAX_IMAGE_W),
      .ADDR_W      (ADDR_W)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (q_not_empty),
      .entry_op    (entry_op),
      .entry_addr  (entry_addr),
      .entry_value (entry_value),
      .pop         (q_pop),
      .clearing    (clearing),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire
